>>> rtl/core/fbsc_pkg.sv
// Shared types and constants for the FASTA base filter / start codon unit.
// No dependencies; used by fbsc_front, fbsc_back and the top level.
package fbsc_pkg;

    // Input beat: raw file byte or a new-sequence marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] byte_in;
    } in_beat_t;

    // Result beat: one kept base.
    typedef struct packed {
        logic [7:0]  base;
        logic [31:0] base_index;
        logic        start_codon;
        logic [31:0] codon_offset;
    } out_beat_t;

    // Command passed from the front to the back.
    typedef struct packed {
        logic       is_clear;
        logic [7:0] base;
    } cmd_t;

    // Input kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Character codes
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
    localparam logic [7:0] CH_SL    = 8'h2F;  // slash
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LC_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LC_Z  = 8'h7A;  // 'z'
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Codon frame position
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // Partial codon match
    typedef enum logic [1:0] {
        MATCH_NONE = 2'd0,
        MATCH_A    = 2'd1,
        MATCH_AT   = 2'd2
    } match_t;

endpackage

>>> rtl/core/fbsc_fifo.sv
// Small register queue with push/full and pop/empty sides.
// No package dependency; used between front and back and at the result side.
module fbsc_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count beyond depth");
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> !empty)
        else $error("pushed beat not visible");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers disagree with count");
`endif

endmodule

>>> rtl/core/fbsc_front.sv
// Front: line/header tracking and byte sanitizing, emits commands.
// Depends on fbsc_pkg.
module fbsc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fbsc_pkg::in_beat_t item,
    output logic              full,
    output logic              cmd_push,
    output fbsc_pkg::cmd_t    cmd,
    input  logic              cmd_full
);

    logic       line_start_reg, line_start_next;
    logic       header_reg, header_next;
    logic       accept;
    logic       is_eol, is_drop, keep;
    logic [7:0] c_up;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    assign is_eol  = (item.byte_in == fbsc_pkg::CH_CR) || (item.byte_in == fbsc_pkg::CH_LF);
    assign is_drop = (item.byte_in == fbsc_pkg::CH_SP)  || (item.byte_in == fbsc_pkg::CH_TAB)
                  || (item.byte_in == fbsc_pkg::CH_VT)  || (item.byte_in == fbsc_pkg::CH_FF)
                  || (item.byte_in == fbsc_pkg::CH_BSL) || (item.byte_in == fbsc_pkg::CH_SL);

    always_comb
    begin
        c_up = item.byte_in;
        if (item.byte_in >= fbsc_pkg::CH_LC_A && item.byte_in <= fbsc_pkg::CH_LC_Z)
        begin
            c_up = item.byte_in - fbsc_pkg::CASE_GAP;
        end
        if (c_up == fbsc_pkg::CH_U)
        begin
            c_up = fbsc_pkg::CH_T;
        end
    end

    always_comb
    begin
        line_start_next = line_start_reg;
        header_next     = header_reg;
        keep            = 1'b0;
        if (accept)
        begin
            priority if (item.kind == fbsc_pkg::KIND_CLEAR)
            begin
                line_start_next = 1'b1;
                header_next     = 1'b0;
            end
            else if (is_eol)
            begin
                line_start_next = 1'b1;
                header_next     = 1'b0;
            end
            else if (header_reg)
            begin
                header_next = 1'b1;
            end
            else if (line_start_reg && item.byte_in == fbsc_pkg::CH_GT)
            begin
                header_next = 1'b1;
            end
            else if (is_drop)
            begin
                line_start_next = line_start_reg;
            end
            else
            begin
                line_start_next = 1'b0;
                keep            = 1'b1;
            end
        end
    end

    assign cmd_push     = accept && ((item.kind == fbsc_pkg::KIND_CLEAR) || keep);
    assign cmd.is_clear = (item.kind == fbsc_pkg::KIND_CLEAR);
    assign cmd.base     = c_up;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            header_reg     <= 1'b0;
        end
        else
        begin
            line_start_reg <= line_start_next;
            header_reg     <= header_next;
        end
    end

endmodule

>>> rtl/core/fbsc_back.sv
// Back: running index, codon frame tracking and ATG flagging.
// Depends on fbsc_pkg.
module fbsc_back #(
    parameter int INDEX_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fbsc_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output logic                res_push,
    output fbsc_pkg::out_beat_t res,
    input  logic                res_full
);

    logic [INDEX_BITS-1:0] counter_reg, counter_next;
    logic [1:0]            phase_reg, phase_next;
    fbsc_pkg::match_t      match_reg, match_next;
    logic [63:0]           idx_wide;
    logic [31:0]           idx32;
    logic                  take, hit;
    logic [1:0]            phase_eff;

    assign take     = !cmd_empty && !res_full;
    assign cmd_pop  = take;
    assign res_push = take && !cmd.is_clear;

    // Index field is 32 bits; counter may be narrower or wider
    assign idx_wide  = 64'(counter_reg);
    assign idx32     = idx_wide[31:0];
    // A phase of 3 never happens; treat it as the codon start
    assign phase_eff = (phase_reg == 2'd3) ? fbsc_pkg::PHASE_0 : phase_reg;
    assign hit       = (phase_eff == fbsc_pkg::PHASE_2) && (match_reg == fbsc_pkg::MATCH_AT)
                    && (cmd.base == fbsc_pkg::CH_G);

    always_comb
    begin
        counter_next = counter_reg;
        phase_next   = phase_reg;
        match_next   = match_reg;
        if (take)
        begin
            if (cmd.is_clear)
            begin
                counter_next = '0;
                phase_next   = fbsc_pkg::PHASE_0;
                match_next   = fbsc_pkg::MATCH_NONE;
            end
            else
            begin
                if (!(&counter_reg))
                begin
                    counter_next = counter_reg + 1'b1;
                end
                unique case (phase_eff)
                    fbsc_pkg::PHASE_0:
                    begin
                        match_next = (cmd.base == fbsc_pkg::CH_A) ? fbsc_pkg::MATCH_A
                                                                  : fbsc_pkg::MATCH_NONE;
                        phase_next = fbsc_pkg::PHASE_1;
                    end
                    fbsc_pkg::PHASE_1:
                    begin
                        match_next = (match_reg == fbsc_pkg::MATCH_A && cmd.base == fbsc_pkg::CH_T)
                                   ? fbsc_pkg::MATCH_AT : fbsc_pkg::MATCH_NONE;
                        phase_next = fbsc_pkg::PHASE_2;
                    end
                    default:
                    begin
                        match_next = fbsc_pkg::MATCH_NONE;
                        phase_next = fbsc_pkg::PHASE_0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res.base         = cmd.base;
        res.base_index   = idx32;
        res.start_codon  = hit;
        res.codon_offset = hit ? (idx32 - 32'd2) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            phase_reg   <= fbsc_pkg::PHASE_0;
            match_reg   <= fbsc_pkg::MATCH_NONE;
        end
        else
        begin
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
            match_reg   <= match_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("codon phase out of range");
    a_match_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (match_reg == fbsc_pkg::MATCH_AT) |-> (phase_reg == fbsc_pkg::PHASE_2))
        else $error("AT match outside third position");
    a_clear_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.is_clear) |=> (counter_reg == '0 && phase_reg == fbsc_pkg::PHASE_0))
        else $error("new sequence did not clear index");
`endif

endmodule

>>> rtl/core/fasta_base_filter_start_codon_unit.sv
// Top level of the FASTA base filter with in-frame start codon flagging.
// Depends on fbsc_pkg, fbsc_front, fbsc_back, fbsc_fifo.
//
//  channel   handshake           payload                  beat moves when
//  --------  ------------------  -----------------------  ----------------------
//  input     push / full         item   (in_beat_t)       push && !full
//  result    empty / pop         result (out_beat_t)      pop && !empty
//
// One input beat per cycle sustained while full is low. A kept byte is
// written into the command queue when accepted, then into the result queue
// once the back takes it, and its result beat can be popped from there.
// Rate is set by the back step: one command per cycle while res_full is low.
// Reset (rst_n low, asynchronous) empties both queues and clears line,
// header, index and codon state. A stalled result side fills the result
// queue, then the command queue, then raises full.
module fasta_base_filter_start_codon_unit #(
    parameter int INDEX_BITS = 32,
    parameter int MID_DEPTH  = 2,
    parameter int OUT_DEPTH  = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  fbsc_pkg::in_beat_t  item,
    output logic                empty,
    input  logic                pop,
    output fbsc_pkg::out_beat_t result
);

    // front -> command queue
    logic           cmd_push, cmd_full;
    fbsc_pkg::cmd_t cmd_in;

    // command queue -> back
    logic           cmd_pop, cmd_empty;
    fbsc_pkg::cmd_t cmd_out;

    // back -> result queue
    logic                res_push, res_full;
    fbsc_pkg::out_beat_t res_in;

    // Front: classifies bytes and drops headers, blanks, slashes and line ends
    fbsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    // Decoupling queue; new-sequence markers travel in order with bases
    fbsc_fifo #(
        .WIDTH ($bits(fbsc_pkg::cmd_t)),
        .DEPTH (MID_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // Back: index counter and codon match
    fbsc_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    // Result queue holds finished beats while the consumer stalls
    fbsc_fifo #(
        .WIDTH ($bits(fbsc_pkg::out_beat_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
